// File: hw/rtl/cmap4_pkg.sv
// Shared types and constants for the cmap format 4 segment lookup unit.
// Used by cmap4_ctrl, cmap4_dp and the top level; depends on nothing.
package cmap4_pkg;

  localparam int unsigned MAX_SEGMENTS = 256;
  localparam int unsigned TABLE_WORDS  = 4096;
  localparam int unsigned SEG_AW       = $clog2(MAX_SEGMENTS);
  localparam int unsigned SEG_CW       = SEG_AW + 1;
  localparam int unsigned TW_AW        = $clog2(TABLE_WORDS);

  localparam logic [15:0] TERMINATOR = 16'hFFFF;
  localparam int unsigned HDR_BYTES  = 14;
  localparam int unsigned MIN_BYTES  = 12;

  // request types
  localparam logic [1:0] REQ_SEG   = 2'd0;
  localparam logic [1:0] REQ_WORD  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // result status codes
  localparam logic [1:0] ST_MAPPED    = 2'd0;
  localparam logic [1:0] ST_UNCOVERED = 2'd1;
  localparam logic [1:0] ST_ERROR     = 2'd2;

  // configuration register indexes
  localparam logic CFG_SEG_COUNT   = 1'b0;
  localparam logic CFG_TABLE_BYTES = 1'b1;

  typedef struct packed {
    logic [15:0] start_cp;
    logic [15:0] end_cp;
    logic [15:0] delta;
    logic [15:0] range_off;
  } cmap4_seg_t;

  typedef struct packed {
    logic seg_wr;
    logic word_wr;
    logic q_start;
    logic issue;
    logic eval;
    logic word_rd;
    logic emit;
  } cmap4_cmd_t;

  typedef struct packed {
    logic done;
    logic more;
  } cmap4_stat_t;

endpackage

// File: hw/rtl/cmap4_ctrl.sv
// Sequencer for the lookup unit: decodes requests and steps a query
// through the segment walk, glyph word read and result. Uses cmap4_pkg.
module cmap4_ctrl import cmap4_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  req_type_i,
  input  cmap4_stat_t stat_i,
  output cmap4_cmd_t  cmd_o,
  output logic        busy_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_WREAD = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.seg_wr  = accept && (req_type_i == REQ_SEG);
        cmd_o.word_wr = accept && (req_type_i == REQ_WORD);
        cmd_o.q_start = accept && (req_type_i == REQ_QUERY);
        if (cmd_o.q_start) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.eval  = 1'b1;
        cmd_o.issue = !stat_i.done && stat_i.more;
        if (stat_i.done) begin
          state_d = S_WREAD;
        end
      end
      S_WREAD: begin
        cmd_o.word_rd = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/cmap4_dp.sv
// Datapath of the lookup unit: config registers, segment and table word
// memories, the segment check/match stage and the result register. Uses cmap4_pkg.
module cmap4_dp import cmap4_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmap4_cmd_t  cmd_i,
  output cmap4_stat_t stat_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [13:0] cfg_wdata_i,
  input  logic [7:0]  seg_index_i,
  input  logic [15:0] seg_start_i,
  input  logic [15:0] seg_end_i,
  input  logic [15:0] seg_delta_i,
  input  logic [15:0] seg_range_offset_i,
  input  logic [11:0] word_addr_i,
  input  logic [15:0] word_value_i,
  input  logic [15:0] codepoint_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] glyph_o
);

  cmap4_seg_t  seg_mem [MAX_SEGMENTS];
  logic [15:0] word_mem [TABLE_WORDS];

  logic [8:0]        seg_count_q;
  logic [13:0]       table_bytes_q;
  logic [SEG_CW-1:0] rd_idx_q;
  logic [SEG_AW-1:0] ev_idx_q;
  logic              ev_valid_q;
  cmap4_seg_t        seg_q;
  logic [15:0]       cp_q;
  logic [11:0]       base_q;
  logic              err_q;
  logic              hit_q;
  logic              need_word_q;
  logic [15:0]       hit_glyph_q;
  logic [15:0]       hit_delta_q;
  logic [16:0]       widx_q;
  logic [15:0]       word_q;
  logic              word_oob_q;
  logic              result_valid_q;
  logic [1:0]        status_q;
  logic [15:0]       glyph_q;

  logic        pre_err;
  logic [14:0] min_bytes;
  logic [11:0] base_d;
  logic        is_last, term, bad_order, ro_bad, brk, seg_err, covers, stop;
  logic [17:0] gbase, run_end, widx_sum;
  logic [16:0] span;
  logic [15:0] cp_off;
  logic        take_hit;
  logic [15:0] word_val;
  logic [15:0] glyph_sum;

  // header checks on the current configuration
  always_comb begin
    min_bytes = {seg_count_q, 3'b000} + 15'(HDR_BYTES);
    base_d    = 12'({seg_count_q, 2'b00} + {seg_count_q, 1'b0}) + 12'(HDR_BYTES);
    pre_err   = (table_bytes_q < 14'(MIN_BYTES)) || (seg_count_q < 9'd2) ||
                (32'(seg_count_q) > MAX_SEGMENTS) || ({1'b0, table_bytes_q} < min_bytes);
  end

  // check and match of the segment in the evaluate stage
  always_comb begin
    is_last   = ({1'b0, ev_idx_q} == (seg_count_q - 9'd1));
    term      = (seg_q.start_cp == TERMINATOR) || (seg_q.end_cp == TERMINATOR);
    bad_order = seg_q.start_cp > seg_q.end_cp;
    gbase     = 18'(base_q) + 18'(seg_q.range_off) + {9'b0, ev_idx_q, 1'b0};
    span      = {1'b0, seg_q.end_cp} - {1'b0, seg_q.start_cp} + 17'd1;
    run_end   = gbase + {span, 1'b0};
    ro_bad    = (seg_q.range_off != 16'd0) &&
                (seg_q.range_off[0] || ({4'b0, table_bytes_q} < run_end));
    brk       = term || bad_order || ro_bad;
    // a terminator ends the walk before any other check of its segment
    seg_err   = term ? !is_last : (bad_order || ro_bad);
    covers    = (cp_q >= seg_q.start_cp) && (cp_q <= seg_q.end_cp);
    cp_off    = cp_q - seg_q.start_cp;
    widx_sum  = gbase + {1'b0, cp_off, 1'b0};
    stop      = ev_valid_q && (brk || is_last);
    take_hit  = cmd_i.eval && ev_valid_q && !brk && covers;
  end

  assign stat_o.done = err_q || stop;
  assign stat_o.more = (rd_idx_q < SEG_CW'(seg_count_q));

  always_comb begin
    word_val  = word_oob_q ? 16'd0 : word_q;
    glyph_sum = word_val + hit_delta_q;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.seg_wr && (32'(seg_index_i) < MAX_SEGMENTS)) begin
      seg_mem[seg_index_i[SEG_AW-1:0]] <= '{start_cp:  seg_start_i,
                                            end_cp:    seg_end_i,
                                            delta:     seg_delta_i,
                                            range_off: seg_range_offset_i};
    end
    if (cmd_i.issue) begin
      seg_q <= seg_mem[rd_idx_q[SEG_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.word_wr && (32'(word_addr_i) < TABLE_WORDS)) begin
      word_mem[word_addr_i[TW_AW-1:0]] <= word_value_i;
    end
    if (cmd_i.word_rd) begin
      word_q     <= word_mem[widx_q[TW_AW-1:0]];
      word_oob_q <= (32'(widx_q) >= TABLE_WORDS);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q    <= '0;
      table_bytes_q  <= '0;
      rd_idx_q       <= '0;
      ev_valid_q     <= 1'b0;
      err_q          <= 1'b0;
      hit_q          <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SEG_COUNT:   seg_count_q   <= cfg_wdata_i[8:0];
          CFG_TABLE_BYTES: table_bytes_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      ev_valid_q     <= cmd_i.issue;
      result_valid_q <= cmd_i.emit;
      if (cmd_i.q_start) begin
        rd_idx_q <= '0;
        err_q    <= pre_err;
        hit_q    <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          rd_idx_q <= rd_idx_q + SEG_CW'(1);
        end
        if (cmd_i.eval && ev_valid_q && seg_err) begin
          err_q <= 1'b1;
        end
        if (take_hit) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) begin
      cp_q   <= codepoint_i;
      base_q <= base_d;
    end
    if (cmd_i.issue) begin
      ev_idx_q <= rd_idx_q[SEG_AW-1:0];
    end
    if (take_hit) begin
      need_word_q <= (seg_q.range_off != 16'd0);
      hit_glyph_q <= cp_q + seg_q.delta;
      hit_delta_q <= seg_q.delta;
      widx_q      <= widx_sum[17:1];
    end
    if (cmd_i.emit) begin
      if (err_q) begin
        status_q <= ST_ERROR;
        glyph_q  <= '0;
      end else if (hit_q) begin
        status_q <= ST_MAPPED;
        glyph_q  <= need_word_q ? ((word_val != 16'd0) ? glyph_sum : 16'd0) : hit_glyph_q;
      end else begin
        status_q <= ST_UNCOVERED;
        glyph_q  <= '0;
      end
    end
  end

  assign result_valid_o = result_valid_q;
  assign status_o       = status_q;
  assign glyph_o        = glyph_q;

  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (rd_idx_q < SEG_CW'(seg_count_q)))
    else $error("segment read issued past the segment count");

  a_error_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && err_q) |=> (status_o == ST_ERROR) && (glyph_o == 16'd0))
    else $error("table error not reported");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

endmodule

// File: hw/rtl/cmap_format4_segment_lookup_unit.sv
// Top level of the cmap format 4 segment lookup unit.
// Instantiates cmap4_ctrl and cmap4_dp; uses cmap4_pkg.
//
// channel   direction  transfer when              payload
// request   in         start_i && !busy_o         req_type_i, seg_*_i, word_*_i, codepoint_i
// result    out        result_valid_o (1 cycle)   status_o, glyph_o
// config    in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// Segment and word loads complete in the cycle they are accepted; busy_o stays low.
// A query holds busy_o while it walks k segments (at most segment_count, zero when
// the header check fails): it issues the first segment read, checks the segments
// one after another, then does one table word read and then forms the result.
// The result strobe comes in the cycle busy_o drops; the receiver cannot stall.
// Reset clears the configuration and control state; memories are not cleared.
module cmap_format4_segment_lookup_unit import cmap4_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  seg_index_i,
  input  logic [15:0] seg_start_i,
  input  logic [15:0] seg_end_i,
  input  logic [15:0] seg_delta_i,
  input  logic [15:0] seg_range_offset_i,
  input  logic [11:0] word_addr_i,
  input  logic [15:0] word_value_i,
  input  logic [15:0] codepoint_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [13:0] cfg_wdata_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] glyph_o
);

  cmap4_cmd_t  cmd;
  cmap4_stat_t stat;

  cmap4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  cmap4_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .seg_index_i        (seg_index_i),
    .seg_start_i        (seg_start_i),
    .seg_end_i          (seg_end_i),
    .seg_delta_i        (seg_delta_i),
    .seg_range_offset_i (seg_range_offset_i),
    .word_addr_i        (word_addr_i),
    .word_value_i       (word_value_i),
    .codepoint_i        (codepoint_i),
    .result_valid_o     (result_valid_o),
    .status_o           (status_o),
    .glyph_o            (glyph_o)
  );

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for cmap_format4_segment_lookup_unit: loads segment tables
// with and without defects, queries codepoints, and checks each result against a model.
// Depends on cmap4_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module testbench;
  import cmap4_pkg::*;

  localparam logic [1:0]  REQ_IGNORED   = 2'd3;
  localparam int unsigned SETTLE_CYCLES = MAX_SEGMENTS + 40;
  localparam int unsigned DRAIN_CYCLES  = 300;
  localparam int unsigned LIMIT_NS      = 4_000_000;
  localparam int unsigned CALM_FROM     = 600;
  localparam int unsigned CALM_TO       = 1000;
  localparam int unsigned MAX_TB_BYTES  = 16383;

  typedef enum int {
    FLAW_NONE, FLAW_EARLY_TERM, FLAW_START_GT_END, FLAW_ODD_OFFSET, FLAW_RUN_PAST_END,
    FLAW_SHORT_TABLE, FLAW_TINY_TABLE, FLAW_FEW_SEGS, FLAW_MANY_SEGS, FLAW_FAR_WORDS,
    FLAW_COUNT
  } flaw_e;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  seg_idx;
    logic [15:0] seg_lo;
    logic [15:0] seg_hi;
    logic [15:0] seg_delta;
    logic [15:0] seg_roff;
    logic [11:0] waddr;
    logic [15:0] wval;
    logic [15:0] cp;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] glyph;
  } lookup_t;

  logic        clk_i;
  logic        rst_ni             = 1'b0;
  logic        start_i            = 1'b0;
  logic [1:0]  req_type_i         = REQ_IGNORED;
  logic [7:0]  seg_index_i        = '0;
  logic [15:0] seg_start_i        = '0;
  logic [15:0] seg_end_i          = '0;
  logic [15:0] seg_delta_i        = '0;
  logic [15:0] seg_range_offset_i = '0;
  logic [11:0] word_addr_i        = '0;
  logic [15:0] word_value_i       = '0;
  logic [15:0] codepoint_i        = '0;
  logic        cfg_we_i           = 1'b0;
  logic        cfg_idx_i          = CFG_SEG_COUNT;
  logic [13:0] cfg_wdata_i        = '0;
  logic        busy_o;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [15:0] glyph_o;

  // shadow of the unit's stores and registers
  logic [15:0] seg_lo_mem     [MAX_SEGMENTS];
  logic [15:0] seg_hi_mem     [MAX_SEGMENTS];
  logic [15:0] seg_delta_mem  [MAX_SEGMENTS];
  logic [15:0] seg_roff_mem   [MAX_SEGMENTS];
  logic [15:0] glyph_word_mem [TABLE_WORDS];
  int unsigned seg_count_cfg   = 0;
  int unsigned table_bytes_cfg = 0;

  request_t    pending_q [$];
  lookup_t     lookup_q  [$];
  request_t    cur_req;
  int unsigned accepted_cnt = 0;
  int unsigned error_cnt    = 0;

  // ranges of the table built last, used to aim queries
  int unsigned built_n;
  logic [15:0] built_lo  [MAX_SEGMENTS];
  int unsigned built_len [MAX_SEGMENTS];

  cmap_format4_segment_lookup_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .req_type_i         (req_type_i),
    .seg_index_i        (seg_index_i),
    .seg_start_i        (seg_start_i),
    .seg_end_i          (seg_end_i),
    .seg_delta_i        (seg_delta_i),
    .seg_range_offset_i (seg_range_offset_i),
    .word_addr_i        (word_addr_i),
    .word_value_i       (word_value_i),
    .codepoint_i        (codepoint_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .result_valid_o     (result_valid_o),
    .status_o           (status_o),
    .glyph_o            (glyph_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic lookup_t map_codepoint(input logic [15:0] cp);
    lookup_t     r;
    int unsigned n, tb, base, s, e, d, ro, gbase, w, c, i;
    logic        err, stop, hit;
    n     = seg_count_cfg;
    tb    = table_bytes_cfg;
    c     = cp;
    base  = n * 6 + HDR_BYTES;
    err   = (tb < MIN_BYTES) || (n < 2) || (n > MAX_SEGMENTS) || (tb < n * 8 + HDR_BYTES);
    stop  = 1'b0;
    hit   = 1'b0;
    r.glyph = '0;
    for (i = 0; i < n && !err && !stop; i++) begin
      s  = seg_lo_mem[i];
      e  = seg_hi_mem[i];
      d  = seg_delta_mem[i];
      ro = seg_roff_mem[i];
      if (s == 32'(TERMINATOR) || e == 32'(TERMINATOR)) begin
        err  = (i != n - 1);
        stop = 1'b1;
      end else if (s > e) begin
        err = 1'b1;
      end else if (ro != 0) begin
        gbase = base + ro + 2 * i;
        if ((ro & 1) != 0 || tb < gbase + (e - s + 1) * 2) begin
          err = 1'b1;
        end else if (c >= s && c <= e) begin
          w       = (gbase + (c - s) * 2) / 2;
          w       = (w < TABLE_WORDS) ? 32'(glyph_word_mem[w]) : 0;
          r.glyph = (w != 0) ? 16'(w + d) : 16'h0000;
          hit     = 1'b1;
        end
      end else if (c >= s && c <= e) begin
        r.glyph = 16'(c + d);
        hit     = 1'b1;
      end
    end
    if (err) begin
      r.status = ST_ERROR;
      r.glyph  = '0;
    end else if (hit) begin
      r.status = ST_MAPPED;
    end else begin
      r.status = ST_UNCOVERED;
      r.glyph  = '0;
    end
    return r;
  endfunction

  function automatic void take_request(input request_t rq);
    case (rq.kind)
      REQ_SEG: begin
        seg_lo_mem[rq.seg_idx]    = rq.seg_lo;
        seg_hi_mem[rq.seg_idx]    = rq.seg_hi;
        seg_delta_mem[rq.seg_idx] = rq.seg_delta;
        seg_roff_mem[rq.seg_idx]  = rq.seg_roff;
      end
      REQ_WORD:  glyph_word_mem[rq.waddr] = rq.wval;
      REQ_QUERY: lookup_q.insert(lookup_q.size(), map_codepoint(rq.cp));
      default: ;
    endcase
  endfunction

  // request driver: hold the item until the transfer, then advance
  always @(posedge clk_i) begin : drive_requests
    logic fire;
    logic go;
    if (rst_ni) begin
      fire = start_i && !busy_o;
      if (fire) begin
        take_request(cur_req);
        accepted_cnt++;
      end
      if (fire || !start_i) begin
        go = (pending_q.size() != 0) &&
             ((accepted_cnt >= CALM_FROM && accepted_cnt < CALM_TO) ||
              $urandom_range(99) >= 6);
        if (go) begin
          cur_req            = pending_q.pop_front();
          req_type_i         <= cur_req.kind;
          seg_index_i        <= cur_req.seg_idx;
          seg_start_i        <= cur_req.seg_lo;
          seg_end_i          <= cur_req.seg_hi;
          seg_delta_i        <= cur_req.seg_delta;
          seg_range_offset_i <= cur_req.seg_roff;
          word_addr_i        <= cur_req.waddr;
          word_value_i       <= cur_req.wval;
          codepoint_i        <= cur_req.cp;
        end
        start_i <= go;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    lookup_t want;
    if (rst_ni && result_valid_o) begin
      if (lookup_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got status %0d glyph %h",
                 $time, status_o, glyph_o);
        error_cnt++;
      end else begin
        want = lookup_q.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, status_o);
          error_cnt++;
        end
        if (glyph_o !== want.glyph) begin
          $display("%0t: glyph mismatch: expected %h, got %h", $time, want.glyph, glyph_o);
          error_cnt++;
        end
      end
    end
  end

  function automatic request_t random_request(input logic [1:0] kind);
    request_t rq;
    rq.kind      = kind;
    rq.seg_idx   = 8'($urandom);
    rq.seg_lo    = 16'($urandom);
    rq.seg_hi    = 16'($urandom);
    rq.seg_delta = 16'($urandom);
    rq.seg_roff  = 16'($urandom);
    rq.waddr     = 12'($urandom);
    rq.wval      = 16'($urandom);
    rq.cp        = 16'($urandom);
    return rq;
  endfunction

  function automatic void push_segment(input int unsigned idx, input logic [15:0] lo,
                                       input logic [15:0] hi, input logic [15:0] delta,
                                       input logic [15:0] roff);
    request_t rq;
    rq           = random_request(REQ_SEG);
    rq.seg_idx   = 8'(idx);
    rq.seg_lo    = lo;
    rq.seg_hi    = hi;
    rq.seg_delta = delta;
    rq.seg_roff  = roff;
    pending_q.insert(pending_q.size(), rq);
  endfunction

  function automatic void push_word(input int unsigned addr, input logic [15:0] val);
    request_t rq;
    rq       = random_request(REQ_WORD);
    rq.waddr = 12'(addr);
    rq.wval  = val;
    pending_q.insert(pending_q.size(), rq);
  endfunction

  function automatic void push_query(input logic [15:0] cp);
    request_t rq;
    rq    = random_request(REQ_QUERY);
    rq.cp = cp;
    pending_q.insert(pending_q.size(), rq);
  endfunction

  function automatic void push_ignored();
    pending_q.insert(pending_q.size(), random_request(REQ_IGNORED));
  endfunction

  task automatic wait_quiet();
    while (pending_q.size() != 0 || start_i || lookup_q.size() != 0) @(negedge clk_i);
  endtask

  // registers change only with the unit idle
  task automatic set_table_config(input int unsigned n_raw, input int unsigned tb);
    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SEG_COUNT;
    cfg_wdata_i <= 14'(n_raw);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TABLE_BYTES;
    cfg_wdata_i <= 14'(tb);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    seg_count_cfg   = n_raw & 32'h1FF;
    table_bytes_cfg = tb & 32'h3FFF;
  endtask

  // queue loads for an n-segment table with one optional defect; return its byte size
  task automatic build_table(input int unsigned n, input flaw_e flaw,
                             output int unsigned tb);
    int unsigned cursor, len, max_len, p, v, i, k;
    logic [15:0] lo, hi, roff;
    logic        use_words;
    cursor  = 0;
    max_len = (n > 32) ? 4 : 40;
    v       = $urandom_range(n - 2);
    for (i = 0; i + 1 < n; i++) begin
      len       = ($urandom_range(3) == 0) ? $urandom_range(max_len, 1) : $urandom_range(4, 1);
      lo        = 16'($urandom_range(32'hFFFF - len));
      hi        = 16'(lo + len - 1);
      use_words = ($urandom_range(1) == 1) || (flaw == FLAW_RUN_PAST_END && i == 0);
      roff      = '0;
      if (flaw == FLAW_FAR_WORDS && i == 0) begin
        // glyph words land past the end of the word store
        roff = 16'(8200 + 2 * $urandom_range(1000));
      end else if (use_words) begin
        p    = 8 * n + HDR_BYTES + 2 * cursor;
        roff = 16'(p - (6 * n + HDR_BYTES) - 2 * i);
        for (k = 0; k < len; k++)
          push_word(p / 2 + k, ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom));
        cursor += len;
      end
      built_lo[i]  = lo;
      built_len[i] = len;
      if (i == v) begin
        case (flaw)
          FLAW_EARLY_TERM: begin
            if ($urandom_range(1) == 1) hi = TERMINATOR;
            else lo = TERMINATOR;
          end
          FLAW_START_GT_END: begin
            if (lo != 0) hi = lo - 1;
            else lo = hi + 1;
          end
          FLAW_ODD_OFFSET: roff = roff | 16'h0001;
          default: ;
        endcase
      end
      push_segment(i, lo, hi, 16'($urandom), roff);
    end
    case ($urandom_range(3))
      0: begin
        lo = 16'($urandom);
        hi = TERMINATOR;
      end
      1: begin
        lo = TERMINATOR;
        hi = 16'($urandom);
      end
      default: begin
        lo = TERMINATOR;
        hi = TERMINATOR;
      end
    endcase
    push_segment(n - 1, lo, hi, 16'($urandom), 16'($urandom));
    built_n = n - 1;
    tb = 8 * n + HDR_BYTES + 2 * cursor;
    case (flaw)
      FLAW_RUN_PAST_END: tb = tb - 1 - $urandom_range(1);
      FLAW_SHORT_TABLE:  tb = 8 * n + HDR_BYTES - 1 - $urandom_range(3);
      FLAW_TINY_TABLE:   tb = $urandom_range(MIN_BYTES - 1);
      FLAW_FAR_WORDS:    tb = MAX_TB_BYTES;
      default:           if ($urandom_range(2) != 0) tb += $urandom_range(40);
    endcase
  endtask

  task automatic run_phase(input int unsigned n, input flaw_e flaw,
                           input int unsigned queries);
    int unsigned tb, n_cfg, j, pick, seg;
    logic [15:0] cp;
    build_table(n, flaw, tb);
    n_cfg = n;
    if (flaw == FLAW_FEW_SEGS) n_cfg = $urandom_range(1);
    if (flaw == FLAW_MANY_SEGS) n_cfg = $urandom_range(511, MAX_SEGMENTS + 1);
    // bits above the count field must be dropped
    if ($urandom_range(3) == 0) n_cfg = n_cfg | ($urandom_range(31) << 9);
    set_table_config(n_cfg, tb);
    for (j = 0; j < queries; j++) begin
      pick = $urandom_range(99);
      seg  = $urandom_range(built_n - 1);
      if (pick < 60) cp = built_lo[seg] + 16'($urandom_range(built_len[seg] - 1));
      else if (pick < 70) cp = built_lo[seg] - 16'd1;
      else if (pick < 80) cp = built_lo[seg] + 16'(built_len[seg]);
      else if (pick < 85) cp = TERMINATOR;
      else cp = 16'($urandom);
      if (pick >= 95) push_ignored();
      else push_query(cp);
    end
  endtask

  initial begin : stimulus
    int unsigned ph, n, r;
    int          f;
    flaw_e       flaw;
    logic [15:0] probe [10] = '{16'h0041, 16'h0043, 16'h1000, 16'h1001, 16'h1002,
                                16'h0000, 16'h0040, 16'h0044, 16'h1003, 16'hFFFF};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers still at reset: every query is a table error
    push_query(16'h0000);
    push_query(16'hFFFF);
    push_ignored();

    // three segments: delta wrap, glyph words 19..21 with a zero word and a wrap
    push_segment(0, 16'h0041, 16'h0043, 16'hFFE0, 16'h0000);
    push_segment(1, 16'h1000, 16'h1002, 16'h0003, 16'h0004);
    push_segment(2, TERMINATOR, TERMINATOR, 16'h0001, 16'h0000);
    push_word(19, 16'h0005);
    push_word(20, 16'h0000);
    push_word(21, 16'hFFFF);
    set_table_config(3, 44);
    foreach (probe[k]) push_query(probe[k]);

    // same segments as a two-entry table with no terminator, largest size
    push_word(17, 16'h0009);
    set_table_config(2, MAX_TB_BYTES);
    push_query(16'h1001);
    push_query(16'h0042);
    set_table_config(MAX_SEGMENTS, MIN_BYTES);
    push_query(16'h0041);
    set_table_config(511, 0);
    push_query(16'h0041);

    for (f = FLAW_NONE; f < FLAW_COUNT; f++) run_phase(4, flaw_e'(f), 3);

    for (ph = 0; ph < 14; ph++) begin
      r = $urandom_range(9);
      if (ph == 0) n = MAX_SEGMENTS;
      else if (r < 7) n = $urandom_range(12, 2);
      else n = $urandom_range(64, 13);
      flaw = ($urandom_range(3) == 0) ? flaw_e'($urandom_range(FLAW_COUNT - 1, 1)) : FLAW_NONE;
      if (ph == 0 || (flaw == FLAW_FAR_WORDS && n > 32)) flaw = FLAW_NONE;
      run_phase(n, flaw, (n == MAX_SEGMENTS) ? 12 : 50);
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
